// File: rtl/cycle_count_timestamp_splitter_core_defines.svh
// ----------------------------------------------------------------------------
// Cycle count timestamp splitter assertion macros
// Concurrent assertion shorthands shared by the core RTL.
// ----------------------------------------------------------------------------
`ifndef CYCLE_COUNT_TIMESTAMP_SPLITTER_CORE_DEFINES_SVH
`define CYCLE_COUNT_TIMESTAMP_SPLITTER_CORE_DEFINES_SVH

// same-cycle implication
`define CCTS_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CCTS_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ccts_pkg.sv
// ----------------------------------------------------------------------------
// ccts_pkg
// Shared widths, constants and types of the cycle count timestamp splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package ccts_pkg;

  localparam int CountW   = 32;
  localparam int TotalW   = 64;
  localparam int FreqW    = 13;
  localparam int SecW     = 45;
  localparam int SubW     = 10;
  localparam int CntW     = 7;
  localparam int OutDataW = 136;

  localparam logic [FreqW-1:0] FreqReset = 13'd168;
  localparam logic [SubW:0]    Kilo      = 11'd1000;
  localparam logic [CntW-1:0]  Steps     = 7'd64;
  localparam logic [CntW-1:0]  CntDone   = 7'd67;

  typedef struct packed {
    logic start;
    logic step;
  } stage_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } state_t;

endpackage

`default_nettype wire

// File: rtl/ccts_extend.sv
// ----------------------------------------------------------------------------
// ccts_extend
// Tracks counter wraps and extends a 32-bit sample to a 64-bit cycle total.
// ----------------------------------------------------------------------------
`default_nettype none

module ccts_extend (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          accept,
  input  wire [ccts_pkg::CountW-1:0]   cycle_count,
  output logic [ccts_pkg::TotalW-1:0]  total
);

  logic [ccts_pkg::CountW-1:0] last_count;
  logic [ccts_pkg::CountW-1:0] wrap_count;
  logic [ccts_pkg::CountW-1:0] wrap_count_next;

  assign wrap_count_next = (cycle_count < last_count) ?
                           wrap_count + ccts_pkg::CountW'(1) : wrap_count;
  assign total = {wrap_count_next, cycle_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      last_count <= '0;
      wrap_count <= '0;
    end else if (accept) begin
      last_count <= cycle_count;
      wrap_count <= wrap_count_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ccts_rate_div.sv
// ----------------------------------------------------------------------------
// ccts_rate_div
// Bit-serial restoring divider of the cycle total by the clock rate in MHz;
// emits one quotient bit per step, most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module ccts_rate_div (
  input  wire                          clk,
  input  wire                          rst,
  input  wire ccts_pkg::stage_ctl_t    ctl,
  input  wire [ccts_pkg::TotalW-1:0]   dividend,
  input  wire [ccts_pkg::FreqW-1:0]    divisor,
  output logic                         q_bit,
  output logic                         q_vld
);

  logic [ccts_pkg::TotalW-1:0] dvd;
  logic [ccts_pkg::FreqW-1:0]  dsr;
  logic [ccts_pkg::FreqW-1:0]  rem;
  logic [ccts_pkg::FreqW:0]    trial;
  logic [ccts_pkg::FreqW:0]    diff;
  logic                        ge;

  assign trial = {rem, dvd[ccts_pkg::TotalW-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd <= dividend;
      dsr <= (divisor == '0) ? ccts_pkg::FreqW'(1) : divisor;
      rem <= '0;
    end else if (ctl.step) begin
      dvd <= {dvd[ccts_pkg::TotalW-2:0], 1'b0};
      rem <= ge ? diff[ccts_pkg::FreqW-1:0] : trial[ccts_pkg::FreqW-1:0];
    end
    q_bit <= ge;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_vld <= 1'b0;
    end else begin
      q_vld <= ctl.step & ~ctl.start;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ccts_kilo_div.sv
// ----------------------------------------------------------------------------
// ccts_kilo_div
// Bit-serial divide-by-1000 stage: consumes a dividend bit stream, emits the
// quotient stream and holds the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module ccts_kilo_div (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire                          in_bit,
  input  wire                          in_vld,
  output logic                         q_bit,
  output logic                         q_vld,
  output logic [ccts_pkg::SubW-1:0]    rem
);

  logic [ccts_pkg::SubW:0] trial;
  logic [ccts_pkg::SubW:0] diff;
  logic                    ge;

  assign trial = {rem, in_bit};
  assign diff  = trial - ccts_pkg::Kilo;
  assign ge    = (trial >= ccts_pkg::Kilo);

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
    end else if (in_vld) begin
      rem <= ge ? diff[ccts_pkg::SubW-1:0] : trial[ccts_pkg::SubW-1:0];
    end
    q_bit <= ge;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_vld <= 1'b0;
    end else begin
      q_vld <= in_vld & ~start;
    end
  end

endmodule

`default_nettype wire

// File: rtl/cycle_count_timestamp_splitter_core.sv
// ----------------------------------------------------------------------------
// cycle_count_timestamp_splitter_core
// Extends 32-bit cycle counter samples to 64 bits and splits the total into
// seconds, milliseconds, microseconds and total microseconds. The 64-step
// bit-serial division of the cycle total by the clock rate comes first; the
// registered quotient bits then drain through the two chained
// divide-by-1000 digit stages, the output register is loaded and the core
// returns to idle. No new sample is taken while the core is busy. A finished
// result waits in the output register while the next sample is already
// taken; a result that is still waiting when the next one finishes holds the
// core until it leaves.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cycle_count_timestamp_splitter_core_defines.svh"

module cycle_count_timestamp_splitter_core (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire [ccts_pkg::FreqW-1:0]        cfg_wdata,     // clock rate in MHz
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire [ccts_pkg::CountW-1:0]       s_axis_tdata,  // cycle_count
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // seconds[44:0], millis[54:45], micros[64:55], total_micros[128:65], zero pad
  output logic [ccts_pkg::OutDataW-1:0]    m_axis_tdata
);

  ccts_pkg::state_t            state;
  ccts_pkg::stage_ctl_t        rate_ctl;
  logic [ccts_pkg::FreqW-1:0]  clk_rate_mhz;
  logic [ccts_pkg::CntW-1:0]   cnt;
  logic [ccts_pkg::TotalW-1:0] total;
  logic [ccts_pkg::TotalW-1:0] total_micros;
  logic [ccts_pkg::SecW-1:0]   seconds;
  logic [ccts_pkg::SubW-1:0]   millis;
  logic [ccts_pkg::SubW-1:0]   micros;
  logic                        s_accept;
  logic                        done;
  logic                        out_load;
  logic                        q1_bit;
  logic                        q1_vld;
  logic                        q2_bit;
  logic                        q2_vld;
  logic                        q3_bit;
  logic                        q3_vld;

  assign s_axis_tready = (state == ccts_pkg::ST_IDLE);
  assign s_accept      = s_axis_tvalid & s_axis_tready;
  assign done          = (state == ccts_pkg::ST_BUSY) && (cnt == ccts_pkg::CntDone);
  assign out_load      = done & (~m_axis_tvalid | m_axis_tready);

  assign rate_ctl.start = s_accept;
  assign rate_ctl.step  = (state == ccts_pkg::ST_BUSY) && (cnt < ccts_pkg::Steps);

  always_ff @(posedge clk) begin
    if (rst) begin
      clk_rate_mhz <= ccts_pkg::FreqReset;
    end else if (cfg_we) begin
      clk_rate_mhz <= cfg_wdata;
    end
  end

  ccts_extend u_extend (
    .clk         (clk),
    .rst         (rst),
    .accept      (s_accept),
    .cycle_count (s_axis_tdata),
    .total       (total)
  );

  ccts_rate_div u_rate_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (rate_ctl),
    .dividend (total),
    .divisor  (clk_rate_mhz),
    .q_bit    (q1_bit),
    .q_vld    (q1_vld)
  );

  ccts_kilo_div u_us_div (
    .clk    (clk),
    .rst    (rst),
    .start  (s_accept),
    .in_bit (q1_bit),
    .in_vld (q1_vld),
    .q_bit  (q2_bit),
    .q_vld  (q2_vld),
    .rem    (micros)
  );

  ccts_kilo_div u_ms_div (
    .clk    (clk),
    .rst    (rst),
    .start  (s_accept),
    .in_bit (q2_bit),
    .in_vld (q2_vld),
    .q_bit  (q3_bit),
    .q_vld  (q3_vld),
    .rem    (millis)
  );

  always_ff @(posedge clk) begin
    if (q1_vld) begin
      total_micros <= {total_micros[ccts_pkg::TotalW-2:0], q1_bit};
    end
    if (q3_vld) begin
      seconds <= {seconds[ccts_pkg::SecW-2:0], q3_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ccts_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        ccts_pkg::ST_IDLE: begin
          if (s_accept) begin
            state <= ccts_pkg::ST_BUSY;
            cnt   <= '0;
          end
        end
        ccts_pkg::ST_BUSY: begin
          if (out_load) begin
            state <= ccts_pkg::ST_IDLE;
          end else if (!done) begin
            cnt <= cnt + ccts_pkg::CntW'(1);
          end
        end
        default: begin
          state <= ccts_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {7'd0, total_micros, micros, millis, seconds};
    end
  end

  `CCTS_ASSERT_NXT(a_accept_busy, clk, rst, s_accept, !s_axis_tready, "accept did not start work")
  `CCTS_ASSERT_NXT(a_stage_chain, clk, rst, q1_vld, q2_vld, "digit stage lost a quotient bit")
  `CCTS_ASSERT_IMP(a_sub_range, clk, rst, out_load,
                   (millis < 10'd1000) && (micros < 10'd1000), "sub-second field out of range")
  `CCTS_ASSERT_IMP(a_out_from_busy, clk, rst, $rose(m_axis_tvalid),
                   $past(state) == ccts_pkg::ST_BUSY, "result raised outside of work")

endmodule

`default_nettype wire

// File: tb/cycle_count_timestamp_splitter_checker.sv
// ----------------------------------------------------------------------------
// cycle_count_timestamp_splitter_checker
// Watches the configuration port and both stream channels of the timestamp
// splitter. Each accepted counter sample is extended with its own wrap count
// and split into seconds, milliseconds, microseconds and total microseconds
// at the current clock rate. Each accepted result is compared field by field
// with the oldest predicted timestamp.
// ----------------------------------------------------------------------------
`default_nettype none

module cycle_count_timestamp_splitter_checker (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire                                     cfg_we,
  input  wire [ccts_pkg::FreqW-1:0]               cfg_wdata,
  input  wire                                     s_tvalid,
  input  wire                                     s_tready,
  input  wire [ccts_pkg::CountW-1:0]              s_tdata,
  input  wire                                     m_tvalid,
  input  wire                                     m_tready,
  input  wire [ccts_pkg::OutDataW-1:0]            m_tdata,
  output int                                      fail_count,
  output int                                      outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ccts_pkg::TotalW-1:0] UsPerSec = 64'd1000000;
  localparam logic [ccts_pkg::TotalW-1:0] UsPerMs  = 64'd1000;

  typedef struct packed {
    logic [ccts_pkg::SecW-1:0]   seconds;
    logic [ccts_pkg::SubW-1:0]   millis;
    logic [ccts_pkg::SubW-1:0]   micros;
    logic [ccts_pkg::TotalW-1:0] total_micros;
  } stamp_t;

  logic [ccts_pkg::FreqW-1:0]  rate_mhz = ccts_pkg::FreqReset;
  logic [ccts_pkg::CountW-1:0] prev_sample = '0;
  logic [ccts_pkg::CountW-1:0] wrap_total = '0;
  stamp_t                      stamp_q[$];
  int                          fails = 0;

  assign fail_count = fails;

  function automatic stamp_t split_cycles(input logic [ccts_pkg::TotalW-1:0] cycles,
                                          input logic [ccts_pkg::FreqW-1:0] mhz_cfg);
    logic [ccts_pkg::TotalW-1:0] mhz;
    logic [ccts_pkg::TotalW-1:0] per_sec;
    logic [ccts_pkg::TotalW-1:0] per_ms;
    logic [ccts_pkg::TotalW-1:0] secs;
    logic [ccts_pkg::TotalW-1:0] ms;
    logic [ccts_pkg::TotalW-1:0] us;
    logic [ccts_pkg::TotalW-1:0] rest;
    stamp_t                      stamp;
    mhz     = (mhz_cfg == '0) ? 64'd1 : ccts_pkg::TotalW'(mhz_cfg);
    per_sec = mhz * UsPerSec;
    per_ms  = mhz * UsPerMs;
    secs    = cycles / per_sec;
    rest    = cycles - secs * per_sec;
    ms      = rest / per_ms;
    rest    = rest - ms * per_ms;
    us      = rest / mhz;
    stamp.seconds      = secs[ccts_pkg::SecW-1:0];
    stamp.millis       = ms[ccts_pkg::SubW-1:0];
    stamp.micros       = us[ccts_pkg::SubW-1:0];
    stamp.total_micros = secs * UsPerSec + ms * UsPerMs + us;
    return stamp;
  endfunction

  task automatic check_field(input string name, input logic [ccts_pkg::TotalW-1:0] want,
                             input logic [ccts_pkg::TotalW-1:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    stamp_t want;
    if (rst) begin
      rate_mhz    = ccts_pkg::FreqReset;
      prev_sample = '0;
      wrap_total  = '0;
      stamp_q.delete();
    end else begin
      if (cfg_we) begin
        rate_mhz = cfg_wdata;
      end
      if (s_tvalid && s_tready) begin
        if (s_tdata < prev_sample) begin
          wrap_total = wrap_total + ccts_pkg::CountW'(1);
        end
        prev_sample = s_tdata;
        stamp_q.push_back(split_cycles({wrap_total, s_tdata}, rate_mhz));
      end
      if (m_tvalid && m_tready) begin
        if (stamp_q.size() == 0) begin
          fails++;
          $display("%0t ns: result transaction expected none actual %0h", $time, m_tdata);
        end else begin
          want = stamp_q.pop_front();
          check_field("seconds", ccts_pkg::TotalW'(want.seconds),
                      ccts_pkg::TotalW'(m_tdata[44:0]));
          check_field("millis", ccts_pkg::TotalW'(want.millis),
                      ccts_pkg::TotalW'(m_tdata[54:45]));
          check_field("micros", ccts_pkg::TotalW'(want.micros),
                      ccts_pkg::TotalW'(m_tdata[64:55]));
          check_field("total_micros", want.total_micros, m_tdata[128:65]);
          check_field("pad", '0, ccts_pkg::TotalW'(m_tdata[ccts_pkg::OutDataW-1:129]));
        end
      end
    end
    outstanding = stamp_q.size();
  end

endmodule

`default_nettype wire

// File: tb/cycle_count_timestamp_splitter_core_tb.sv
// ----------------------------------------------------------------------------
// cycle_count_timestamp_splitter_core_tb
// Drives counter samples into the timestamp splitter under a series of clock
// rates, zero and out-of-range rates included. A directed opening covers the
// sample extremes, repeated samples and wraps; the random part is mostly
// rising sample runs with wraps, mixed with noise. Both channels idle in
// random bursts; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module cycle_count_timestamp_splitter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomPhases = 11;
  localparam int PhaseItems   = 150;
  localparam int DrainCycles  = 80;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [ccts_pkg::FreqW-1:0]    cfg_wdata = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [ccts_pkg::CountW-1:0]   s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [ccts_pkg::OutDataW-1:0] m_axis_tdata;

  int fail_count;
  int outstanding;
  int samples_sent = 0;
  int rates_used = 0;
  bit quiet = 1'b0;

  always #4 clk = ~clk;

  cycle_count_timestamp_splitter_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  cycle_count_timestamp_splitter_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .s_tvalid    (s_axis_tvalid),
    .s_tready    (s_axis_tready),
    .s_tdata     (s_axis_tdata),
    .m_tvalid    (m_axis_tvalid),
    .m_tready    (m_axis_tready),
    .m_tdata     (m_axis_tdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  task automatic send_sample(input logic [ccts_pkg::CountW-1:0] value);
    logic took;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do begin
      @(negedge clk);
      took = s_axis_tready;
      @(posedge clk);
    end while (!took);
    samples_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic set_rate(input logic [ccts_pkg::FreqW-1:0] mhz);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= mhz;
    @(posedge clk);
    cfg_we    <= 1'b0;
    rates_used++;
  endtask

  // result side: stall in random bursts, hold ready high once quiet
  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    logic [ccts_pkg::CountW-1:0] sample;
    logic [ccts_pkg::FreqW-1:0]  mhz;
    sample = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_sample(32'h0000_0000);
    send_sample(32'h0000_0000);
    send_sample(32'h0000_0001);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0000);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h5555_5555);
    send_sample(32'hAAAA_AAAA);

    set_rate(13'd0);
    send_sample(32'd999_999);
    send_sample(32'd1_000_000);
    send_sample(32'd0);
    set_rate(13'd1);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'd12_345);
    set_rate(13'd4294);
    send_sample(32'hFFFF_FFFE);
    send_sample(32'h0000_0010);
    set_rate(13'h1FFF);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0001);
    sample = 32'h0000_0001;

    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0: mhz = 13'd1;
        1: mhz = 13'd4294;
        2: mhz = 13'h1FFF;
        3: mhz = 13'd0;
        default: begin
          case ($urandom_range(0, 3))
            0: mhz = ccts_pkg::FreqW'($urandom);
            1: mhz = ccts_pkg::FreqW'($urandom_range(1, 4294));
            2: mhz = ccts_pkg::FreqW'($urandom_range(1, 16));
            default: mhz = ccts_pkg::FreqReset;
          endcase
        end
      endcase
      set_rate(mhz);
      if (p == RandomPhases - 1) begin
        quiet = 1'b1;
      end
      for (int i = 0; i < PhaseItems; i++) begin
        if (p == 4 && i == PhaseItems / 2) begin
          drain_results();
        end
        case ($urandom_range(0, 9))
          0: sample = $urandom;
          1: sample = 32'hFFFF_FFFF - ccts_pkg::CountW'($urandom_range(0, 3));
          2: sample = sample;
          3, 4: sample = sample + ccts_pkg::CountW'($urandom);
          5, 6: sample = sample + ccts_pkg::CountW'($urandom_range(0, 1_000_000));
          default: sample = sample + ccts_pkg::CountW'($urandom_range(1, 5000));
        endcase
        send_sample(sample);
      end
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk);
    $display("Sent %0d counter samples over %0d clock-rate settings (zero, 1, 4294, 8191",
             samples_sent, rates_used);
    $display("and random rates), with rising runs, wraps, repeats and noise under stalls.");
    if (fail_count == 0) begin
      $display("cycle_count_timestamp_splitter_core: match");
    end else begin
      $display("cycle_count_timestamp_splitter_core: mismatch");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("cycle_count_timestamp_splitter_core: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

// File: cycle_count_timestamp_splitter_core.f
+incdir+rtl
rtl/ccts_pkg.sv
rtl/ccts_extend.sv
rtl/ccts_rate_div.sv
rtl/ccts_kilo_div.sv
rtl/cycle_count_timestamp_splitter_core.sv
tb/cycle_count_timestamp_splitter_checker.sv
tb/cycle_count_timestamp_splitter_core_tb.sv
